// File: hdl/compacting_array_queue_unit_assert.svh
// Assertion macros used by the queue unit's datapath.
`ifndef COMPACTING_ARRAY_QUEUE_UNIT_ASSERT_SVH
`define COMPACTING_ARRAY_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAQU_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CAQU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue unit: next-cycle check failed");

`endif

// File: hdl/caqu_pkg.sv
`timescale 1ns / 1ps

package caqu_pkg;

   // Field widths fixed by the item format.
   localparam int BYTE_W = 8;
   localparam int OCC_W  = 4;

   // Byte returned when nothing is taken from the queue.
   localparam logic [BYTE_W-1:0] FILLER = 8'd35;

   // Action codes.
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic in_ready;
      logic capture;
      logic deq_read;
      logic deq_take;
      logic cmp_start;
      logic cmp_step;
      logic enq_write;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_valid;
      logic in_deq;
      logic empty;
      logic full;
      logic back_cap;
      logic cmp_last;
      logic out_free;
   } status_type;

endpackage

// File: hdl/caqu_if.sv
`timescale 1ns / 1ps

// Request channel: one queue operation per transfer.
interface caqu_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [caqu_pkg::BYTE_W-1:0] item_data;

   modport source (output valid, output action, output item_data, input ready);
   modport sink   (input valid, input action, input item_data, output ready);
endinterface

// Response channel: one result per request.
interface caqu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [caqu_pkg::BYTE_W-1:0] front_out;
   logic                       took_item;
   logic                       stored;
   logic [caqu_pkg::OCC_W-1:0]  occupancy;
   logic                       empty_flag;
   logic                       full_flag;

   modport source (output valid, output front_out, output took_item, output stored,
                   output occupancy, output empty_flag, output full_flag, input ready);
   modport sink   (input valid, input front_out, input took_item, input stored,
                   input occupancy, input empty_flag, input full_flag, output ready);
endinterface

// File: hdl/caqu_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and one registered read port.
module caqu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/caqu_ctrl.sv
`timescale 1ns / 1ps

// Sequencer for one queue operation at a time.
module caqu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  caqu_pkg::status_type st,
   output caqu_pkg::cmd_type    cmd
);

   import caqu_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPACT,
      S_ENQ,
      S_DEQ_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (st.in_valid) begin
               cmd.capture = 1'b1;
               if (st.in_deq == ACT_DEQUEUE) begin
                  if (st.empty) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.deq_read = 1'b1;
                     state_in     = S_DEQ_WAIT;
                  end
               end else if (st.full) begin
                  state_in = S_FINISH;
               end else if (st.back_cap) begin
                  cmd.cmp_start = 1'b1;
                  state_in      = S_COMPACT;
               end else begin
                  state_in = S_ENQ;
               end
            end
         end
         S_COMPACT: begin
            cmd.cmp_step = 1'b1;
            if (st.cmp_last) begin
               state_in = S_ENQ;
            end
         end
         S_ENQ: begin
            cmd.enq_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_DEQ_WAIT: begin
            cmd.deq_take = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/caqu_datapath.sv
`timescale 1ns / 1ps
`include "compacting_array_queue_unit_assert.svh"

// Queue pointers, slot memory, compaction mover and result register.
module caqu_datapath #(
   parameter int CAPACITY = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   caqu_req_if.sink             req_chan,
   caqu_rsp_if.source           rsp_chan,
   input  caqu_pkg::cmd_type    cmd,
   output caqu_pkg::status_type st
);

   import caqu_pkg::*;

   // Positions run 1..CAPACITY; the compaction source pointer reaches CAPACITY + 1.
   localparam int PW = $clog2(CAPACITY + 2);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [PW-1:0] POS_ONE = PW'(1);
   localparam logic [PW-1:0] POS_CAP = PW'(CAPACITY);

   logic [PW-1:0]     front_ff;
   logic [PW-1:0]     back_ff;
   logic [PW-1:0]     src_ff;
   logic [PW-1:0]     dst_ff;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] res_byte_ff;
   logic              took_ff;
   logic              stored_ff;

   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_took_ff;
   logic              out_stored_ff;
   logic [OCC_W-1:0]  out_occ_ff;
   logic              out_empty_ff;
   logic              out_full_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic              is_empty;
   logic              is_full;
   logic              src_in_range;
   logic [PW-1:0]     front_m1;
   logic [PW-1:0]     src_m1;
   logic [PW-1:0]     dst_m1;
   logic [PW-1:0]     count;

   // Slot array. Only occupied slots are ever read, so it needs no clearing.
   caqu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Queue state decode.
   assign is_empty     = (front_ff == '0) && (back_ff == '0);
   assign is_full      = (front_ff == POS_ONE) && (back_ff == POS_CAP);
   assign src_in_range = (src_ff <= back_ff);
   assign front_m1     = front_ff - POS_ONE;
   assign src_m1       = src_ff - POS_ONE;
   assign dst_m1       = dst_ff - POS_ONE;
   assign count        = is_empty ? '0 : (back_ff - front_ff + POS_ONE);

   assign st.in_valid = req_chan.valid;
   assign st.in_deq   = req_chan.action;
   assign st.empty    = is_empty;
   assign st.full     = is_full;
   assign st.back_cap = (back_ff == POS_CAP);
   assign st.cmp_last = !src_in_range;
   assign st.out_free = !out_valid_ff || rsp_chan.ready;

   assign req_chan.ready = cmd.in_ready;

   // Memory port selection.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = back_ff[AW-1:0];
      ram_wdata = data_ff;
      ram_re    = 1'b0;
      ram_raddr = front_m1[AW-1:0];
      if (cmd.deq_read || cmd.cmp_start) begin
         ram_re = 1'b1;
      end
      if (cmd.cmp_step) begin
         ram_we    = 1'b1;
         ram_waddr = dst_m1[AW-1:0];
         ram_wdata = ram_rdata;
         ram_re    = src_in_range;
         ram_raddr = src_m1[AW-1:0];
      end
      if (cmd.enq_write) begin
         ram_we = 1'b1;
      end
   end

   // Pointers and per-operation result.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
      end else begin
         if (cmd.deq_take) begin
            if (front_ff == back_ff) begin
               front_ff <= '0;
               back_ff  <= '0;
            end else begin
               front_ff <= front_ff + POS_ONE;
            end
         end
         if (cmd.cmp_step && !src_in_range) begin
            front_ff <= POS_ONE;
            back_ff  <= dst_ff;
         end
         if (cmd.enq_write) begin
            if (back_ff == '0) begin
               front_ff <= POS_ONE;
            end
            back_ff <= back_ff + POS_ONE;
         end
      end
   end

   // Compaction pointers, latched input and result fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         data_ff     <= req_chan.item_data;
         res_byte_ff <= FILLER;
         took_ff     <= 1'b0;
         stored_ff   <= 1'b0;
      end
      if (cmd.cmp_start) begin
         src_ff <= front_ff + POS_ONE;
         dst_ff <= POS_ONE;
      end
      if (cmd.cmp_step) begin
         dst_ff <= dst_ff + POS_ONE;
         if (src_in_range) begin
            src_ff <= src_ff + POS_ONE;
         end
      end
      if (cmd.deq_take) begin
         res_byte_ff <= ram_rdata;
         took_ff     <= 1'b1;
      end
      if (cmd.enq_write) begin
         stored_ff <= 1'b1;
      end
   end

   // Output register: holds the result until the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_byte_ff   <= res_byte_ff;
         out_took_ff   <= took_ff;
         out_stored_ff <= stored_ff;
         out_occ_ff    <= OCC_W'(count);
         out_empty_ff  <= is_empty;
         out_full_ff   <= is_full;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.front_out  = out_byte_ff;
   assign rsp_chan.took_item  = out_took_ff;
   assign rsp_chan.stored     = out_stored_ff;
   assign rsp_chan.occupancy  = out_occ_ff;
   assign rsp_chan.empty_flag = out_empty_ff;
   assign rsp_chan.full_flag  = out_full_ff;

   // Checks on pointer consistency and the compaction sequence.
   `CAQU_ASSERT_HOLDS(a_ptr_order, clock, reset, front_ff != '0, (front_ff <= back_ff) && (back_ff <= POS_CAP))
   `CAQU_ASSERT_HOLDS(a_ptr_empty, clock, reset, front_ff == '0, back_ff == '0)
   `CAQU_ASSERT_HOLDS(a_cmp_tail, clock, reset, cmd.cmp_step, back_ff == POS_CAP)
   `CAQU_ASSERT_HOLDS(a_cmp_order, clock, reset, cmd.cmp_step && src_in_range, dst_ff < src_ff)
   `CAQU_ASSERT_NEXT(a_cmp_begin, clock, reset, cmd.cmp_start, cmd.cmp_step)

endmodule

// File: hdl/compacting_array_queue_unit.sv
`timescale 1ns / 1ps

// Byte queue held in a CAPACITY-entry array whose head advances on each dequeue.
// Each request is one transfer carrying an action (enqueue or dequeue) and a byte;
// each gives exactly one response carrying the dequeued byte (or '#'), whether a
// byte was taken or stored, and the occupancy and empty and full flags after the
// operation. Operations run one at a time. When the tail has reached CAPACITY with
// free slots at the front, an enqueue first moves the n stored bytes (at most
// CAPACITY - 1) down to position 1, one byte per cycle through the slot memory's
// read and write ports. A new request is taken while the previous response still
// waits in the output register. No clearing pass is needed after reset.
module compacting_array_queue_unit #(
   parameter int CAPACITY = 8
) (
   input logic        clock,
   input logic        reset,
   caqu_req_if.sink   req_chan,
   caqu_rsp_if.source rsp_chan
);

   import caqu_pkg::*;

   cmd_type    cmd;
   status_type st;

   caqu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   caqu_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .st       (st)
   );

endmodule

// File: sim/caqu_response_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the queue unit, keeps its own copy of the queue and
// compares every response transfer with the result that it predicts.
module caqu_response_checker #(
   parameter int CAPACITY = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_action,
   input  logic [caqu_pkg::BYTE_W-1:0]  req_item_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [caqu_pkg::BYTE_W-1:0]  rsp_front_out,
   input  logic                         rsp_took_item,
   input  logic                         rsp_stored,
   input  logic [caqu_pkg::OCC_W-1:0]   rsp_occupancy,
   input  logic                         rsp_empty_flag,
   input  logic                         rsp_full_flag,
   output int                           error_count,
   output int                           pending_count,
   output int                           checked_count,
   output int                           compaction_count,
   output int                           drop_count,
   output int                           empty_deq_count
);

   import caqu_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] front_out;
      logic              took_item;
      logic              stored;
      logic [OCC_W-1:0]  occupancy;
      logic              empty_flag;
      logic              full_flag;
   } queue_result_type;

   // Results still owed by the unit, oldest first.
   queue_result_type awaited_results[$];

   // Shadow copy of the queue; positions run from 1 and both are 0 when empty.
   logic [BYTE_W-1:0] slot_mem [1:CAPACITY];
   int unsigned       head_pos;
   int unsigned       tail_pos;

   function automatic logic queue_is_empty();
      return head_pos == 0 && tail_pos == 0;
   endfunction

   function automatic logic queue_is_full();
      return head_pos == 1 && tail_pos == CAPACITY;
   endfunction

   // Applies one operation to the shadow queue and returns the result it gives.
   function automatic queue_result_type queue_apply(input logic act,
                                                    input logic [BYTE_W-1:0] data);
      queue_result_type res;
      int unsigned      src;
      int unsigned      dst;
      res = '0;
      res.front_out = FILLER;
      if (act == ACT_ENQUEUE) begin
         if (queue_is_full()) begin
            drop_count++;
         end else begin
            // The tail has hit the end with room at the front: slide everything down.
            if (tail_pos == CAPACITY) begin
               dst = 0;
               for (src = head_pos; src <= tail_pos; src++) begin
                  dst++;
                  slot_mem[dst] = slot_mem[src];
                  if (src != dst)
                     slot_mem[src] = FILLER;
               end
               head_pos = 1;
               tail_pos = dst;
               compaction_count++;
            end
            if (queue_is_empty())
               head_pos = 1;
            tail_pos++;
            slot_mem[tail_pos] = data;
            res.stored = 1'b1;
         end
      end else begin
         if (queue_is_empty()) begin
            empty_deq_count++;
         end else begin
            res.front_out = slot_mem[head_pos];
            res.took_item = 1'b1;
            slot_mem[head_pos] = FILLER;
            // Taking the last byte returns both positions to zero.
            if (head_pos == tail_pos) begin
               head_pos = 0;
               tail_pos = 0;
            end else begin
               head_pos++;
            end
         end
      end
      res.occupancy  = queue_is_empty() ? '0 : OCC_W'(tail_pos - head_pos + 1);
      res.empty_flag = queue_is_empty();
      res.full_flag  = queue_is_full();
      return res;
   endfunction

   task automatic report_failure(input string what, input queue_result_type want,
                                 input queue_result_type seen);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected front=%h took=%b stored=%b occ=%0d empty=%b full=%b",
                  want.front_out, want.took_item, want.stored, want.occupancy,
                  want.empty_flag, want.full_flag);
         $display("   actual   front=%h took=%b stored=%b occ=%0d empty=%b full=%b",
                  seen.front_out, seen.took_item, seen.stored, seen.occupancy,
                  seen.empty_flag, seen.full_flag);
      end
   endtask

   // A response is checked before a request of the same edge is predicted, so a
   // response can never be matched with an operation taken at that very edge.
   always @(posedge clock) begin
      queue_result_type seen;
      queue_result_type want;
      if (reset) begin
         awaited_results.delete();
         for (int i = 1; i <= CAPACITY; i++)
            slot_mem[i] = FILLER;
         head_pos         = 0;
         tail_pos         = 0;
         error_count      = 0;
         checked_count    = 0;
         compaction_count = 0;
         drop_count       = 0;
         empty_deq_count  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{front_out: rsp_front_out, took_item: rsp_took_item,
                     stored: rsp_stored, occupancy: rsp_occupancy,
                     empty_flag: rsp_empty_flag, full_flag: rsp_full_flag};
            if (awaited_results.size() == 0) begin
               report_failure("response transfer with no request outstanding",
                              '0, seen);
            end else begin
               want = awaited_results.pop_front();
               checked_count++;
               if (seen !== want)
                  report_failure("response mismatch", want, seen);
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(queue_apply(req_action, req_item_data));
      end
      pending_count = awaited_results.size();
   end

endmodule

// File: sim/compacting_array_queue_unit_tb.sv
`timescale 1ns / 1ps

// Drives the queue unit with directed and random operations and gives the verdict.
module compacting_array_queue_unit_tb;
   import caqu_pkg::*;

   localparam int CAPACITY     = 8;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [BYTE_W-1:0] EDGE_BYTES [0:7] =
      '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, FILLER};

   logic clock = 1'b0;
   logic reset = 1'b1;

   int error_count;
   int pending_count;
   int checked_count;
   int compaction_count;
   int drop_count;
   int empty_deq_count;

   int stall_mode = 0;
   int stall_left = 0;

   caqu_req_if req_chan ();
   caqu_rsp_if rsp_chan ();

   always #5 clock = ~clock;

   compacting_array_queue_unit #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   caqu_response_checker #(
      .CAPACITY (CAPACITY)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_action       (req_chan.action),
      .req_item_data    (req_chan.item_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_front_out    (rsp_chan.front_out),
      .rsp_took_item    (rsp_chan.took_item),
      .rsp_stored       (rsp_chan.stored),
      .rsp_occupancy    (rsp_chan.occupancy),
      .rsp_empty_flag   (rsp_chan.empty_flag),
      .rsp_full_flag    (rsp_chan.full_flag),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .compaction_count (compaction_count),
      .drop_count       (drop_count),
      .empty_deq_count  (empty_deq_count)
   );

   // The response side switches between free flow, light, heavy and periodic stalls.
   initial rsp_chan.ready = 1'b0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 150);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_chan.ready = 1'b1;
         1: rsp_chan.ready = ($urandom_range(0, 3) != 0);
         2: rsp_chan.ready = ($urandom_range(0, 4) == 0);
         default: rsp_chan.ready = ((stall_left % 5) < 2);
      endcase
   end

   // Presents one operation from a falling edge and holds it until its transfer.
   task automatic send_op(input logic act, input logic [BYTE_W-1:0] data);
      req_chan.valid     = 1'b1;
      req_chan.action    = act;
      req_chan.item_data = data;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      req_chan.valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Stops a run that hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d results outstanding",
               CYCLE_LIMIT, pending_count);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int sent;
      int burst;
      int seg_left;
      int enq_pct;
      logic act;

      req_chan.valid     = 1'b0;
      req_chan.action    = ACT_ENQUEUE;
      req_chan.item_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Dequeue from the empty queue, then fill it with edge-case bytes.
      send_op(ACT_DEQUEUE, 8'hFF);
      for (int i = 0; i < CAPACITY; i++)
         send_op(ACT_ENQUEUE, EDGE_BYTES[i % 8]);
      // An enqueue into the full queue is dropped.
      send_op(ACT_ENQUEUE, 8'h5A);
      // Free the front slot, then enqueue: the longest compaction.
      send_op(ACT_DEQUEUE, 8'h00);
      idle_gap(3);
      send_op(ACT_ENQUEUE, 8'hC3);
      // Leave only the last slot in use, then enqueue: a one-byte compaction.
      repeat (CAPACITY - 1) send_op(ACT_DEQUEUE, 8'h00);
      send_op(ACT_ENQUEUE, FILLER);
      // Drain to empty, including the last-byte case, and dequeue once more.
      repeat (3) send_op(ACT_DEQUEUE, 8'hFF);
      idle_gap(4);

      // Random bursts; each segment leans towards filling, draining or neither,
      // so that the queue often reaches full, empty and the compaction point.
      sent     = 0;
      seg_left = 0;
      enq_pct  = 50;
      while (sent < RANDOM_ITEMS) begin
         if (seg_left <= 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 20;
               1: enq_pct = 50;
               default: enq_pct = 80;
            endcase
            seg_left = $urandom_range(8, 40);
         end
         burst = $urandom_range(1, 16);
         for (int k = 0; k < burst; k++) begin
            act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
            send_op(act, BYTE_W'($urandom_range(0, 255)));
            sent++;
            seg_left--;
         end
         if ($urandom_range(0, 2) != 0)
            idle_gap($urandom_range(1, 12));
      end
      req_chan.valid = 1'b0;

      // Let the outstanding results drain, then allow for the longest operation.
      while (pending_count != 0)
         @(negedge clock);
      repeat (CAPACITY + 10) @(negedge clock);

      $display("Checked %0d results: %0d compactions, %0d dropped enqueues,",
               checked_count, compaction_count, drop_count);
      $display("%0d dequeues from empty, %0d mismatches.", empty_deq_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
